>>> rtl/core/pcr_pkg.sv
`default_nettype none

package pcr_pkg;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pix_type;

   // Adjustment chosen by the hue match: luma blend weight, green-into-red mix,
   // and per-channel percentage scales (PCT_UNITY leaves a channel alone).
   typedef struct packed {
      logic [7:0] weight;
      logic       mix;
      logic [6:0] k_red;
      logic [6:0] k_green;
      logic [6:0] k_blue;
   } adj_type;

   localparam logic [2:0] PROF_OFF        = 3'd0;
   localparam logic [2:0] PROF_PURPLE     = 3'd1;
   localparam logic [2:0] PROF_CYAN       = 3'd2;
   localparam logic [2:0] PROF_RED_CYAN   = 3'd3;
   localparam logic [2:0] PROF_BLUE_GREEN = 3'd4;
   localparam logic [2:0] PROF_BLUE_RED   = 3'd5;

   localparam logic [15:0] LUMA_KR = 16'd54;
   localparam logic [15:0] LUMA_KG = 16'd183;
   localparam logic [15:0] LUMA_KB = 16'd19;

   localparam logic [7:0] BASE_MAX_LIMIT  = 8'd228;
   localparam logic [7:0] LOW_MAX_LIMIT   = 8'd232;
   localparam logic [7:0] BASE_LUMA_MIN   = 8'd24;
   localparam logic [7:0] BASE_CHROMA_MIN = 8'd34;
   localparam logic [7:0] BASE_WEIGHT     = 8'd24;

   localparam logic [6:0]  PCT_UNITY    = 7'd100;
   // floor(p / 100) == (p * 5243) >> 19 for every p below 25600
   localparam logic [27:0] DIV100_MUL   = 28'd5243;
   localparam int          DIV100_SHIFT = 19;

   function automatic logic [7:0] luma_of(input pix_type p);
      logic [15:0] sum;
      sum = {8'd0, p.red} * LUMA_KR + {8'd0, p.green} * LUMA_KG
          + {8'd0, p.blue} * LUMA_KB;
      return sum[15:8];
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/pixel_color_restraint.sv
// pixel_color_restraint: per-pixel tint restraint for 8-bit RGB video.
// Pixels enter on the req_ channel (valid/ready, payload req_data) and leave
// on the rsp_ channel (valid/ready, payload rsp_data), one result per item,
// in order. csr_wr_en/csr_wr_data write the 3-bit tint profile; write it only
// while the pipeline is empty.
// The datapath is a six-stage pipeline: statistics and luma, base blend,
// second luma and hue match, weighted blend, percentage product, divide by
// 100 through a reciprocal multiply. An accepted item moves through the stage
// registers in order until rsp_valid shows it; throughput is one item per clock
// while rsp_ready stays high, set by the per-stage registers, each carrying one
// multiply level.
// Each stage has its own valid bit and loads when it is empty or when the
// stage after it moves, so bubbles close up and req_ready stays high while
// any stage is free; a stalled receiver backs the pipe up stage by stage
// and nothing is lost or repeated.
// Synchronous reset empties every stage and sets the profile to off
// (pass-through).
`default_nettype none

module pixel_color_restraint
   import pcr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_wr_data
);

   logic [2:0] tint_profile_ff;

   // stage valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic adv1, adv2, adv3, adv4, adv5, adv6;

   // stage 1: incoming pixel and its statistics
   pix_type    s1_pix_ff, s1_pix_in;
   logic [7:0] s1_luma_ff, s1_luma_in;
   logic       s1_base_ff, s1_base_in;
   logic       s1_low_ff, s1_low_in;
   logic [2:0] s1_prof_ff;

   // stage 2: after base blend
   pix_type    s2_pix_ff, s2_pix_in, s2_blend;
   logic       s2_low_ff;
   logic [2:0] s2_prof_ff;

   // stage 3: pixel, its luma and the chosen adjustment
   pix_type    s3_pix_ff;
   logic [7:0] s3_luma_ff, s3_luma_in;
   adj_type    s3_adj_ff, s3_adj_in;

   // stage 4: after weighted blend or green mix
   pix_type    s4_pix_ff, s4_pix_in, s4_blend;
   logic [6:0] s4_kr_ff, s4_kg_ff, s4_kb_ff;
   logic [11:0] mix_sum;

   // stage 5: percentage products
   logic [14:0] s5_pr_ff, s5_pr_in;
   logic [14:0] s5_pg_ff, s5_pg_in;
   logic [14:0] s5_pb_ff, s5_pb_in;

   // stage 6: result
   pix_type     s6_pix_ff, s6_pix_in;
   logic [27:0] q_r, q_g, q_b;

   // a stage loads when empty or when its contents move on
   always_comb begin
      adv6 = rsp_ready || !v6_ff;
      adv5 = adv6 || !v5_ff;
      adv4 = adv5 || !v4_ff;
      adv3 = adv4 || !v3_ff;
      adv2 = adv3 || !v2_ff;
      adv1 = adv2 || !v1_ff;
   end

   assign req_ready = adv1;
   assign rsp_valid = v6_ff;
   assign rsp_data.red_out   = s6_pix_ff.red;
   assign rsp_data.green_out = s6_pix_ff.green;
   assign rsp_data.blue_out  = s6_pix_ff.blue;

   always_ff @(posedge clock) begin
      if (reset) begin
         tint_profile_ff <= PROF_OFF;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tint_profile_ff <= csr_wr_data;
         end
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
         if (adv6) v6_ff <= v5_ff;
      end
   end

   // stage 1: max, min, chroma, luma and the base-blend decision
   always_comb begin
      s1_pix_in.red   = req_data.red_in;
      s1_pix_in.green = req_data.green_in;
      s1_pix_in.blue  = req_data.blue_in;
   end

   pcr_stats u_stats (
      .pix     (s1_pix_in),
      .profile (tint_profile_ff),
      .luma    (s1_luma_in),
      .base_en (s1_base_in),
      .low     (s1_low_in)
   );

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_pix_ff  <= s1_pix_in;
         s1_luma_ff <= s1_luma_in;
         s1_base_ff <= s1_base_in;
         s1_low_ff  <= s1_low_in;
         s1_prof_ff <= tint_profile_ff;
      end
   end

   // stage 2: blend mid-range saturated pixels 24/256 toward luma
   pcr_blend u_base_blend (
      .pix     (s1_pix_ff),
      .luma    (s1_luma_ff),
      .weight  (BASE_WEIGHT),
      .blended (s2_blend)
   );

   assign s2_pix_in = s1_base_ff ? s2_blend : s1_pix_ff;

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_pix_ff  <= s2_pix_in;
         s2_low_ff  <= s1_low_ff;
         s2_prof_ff <= s1_prof_ff;
      end
   end

   // stage 3: luma of the blended pixel and the hue match
   assign s3_luma_in = luma_of(s2_pix_ff);

   pcr_select u_select (
      .pix     (s2_pix_ff),
      .low     (s2_low_ff),
      .profile (s2_prof_ff),
      .adj     (s3_adj_in)
   );

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_pix_ff  <= s2_pix_ff;
         s3_luma_ff <= s3_luma_in;
         s3_adj_ff  <= s3_adj_in;
      end
   end

   // stage 4: weighted blend (weight zero leaves the pixel as is), or mix
   // green into red for the blue-or-green profile's green case
   pcr_blend u_hue_blend (
      .pix     (s3_pix_ff),
      .luma    (s3_luma_ff),
      .weight  (s3_adj_ff.weight),
      .blended (s4_blend)
   );

   always_comb begin
      mix_sum   = {4'd0, s3_pix_ff.red} * 12'd15 + {4'd0, s3_pix_ff.green};
      s4_pix_in = s4_blend;
      if (s3_adj_ff.mix) begin
         s4_pix_in.red = mix_sum[11:4];
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         s4_pix_ff <= s4_pix_in;
         s4_kr_ff  <= s3_adj_ff.k_red;
         s4_kg_ff  <= s3_adj_ff.k_green;
         s4_kb_ff  <= s3_adj_ff.k_blue;
      end
   end

   // stage 5: x * k
   always_comb begin
      s5_pr_in = {7'd0, s4_pix_ff.red}   * {8'd0, s4_kr_ff};
      s5_pg_in = {7'd0, s4_pix_ff.green} * {8'd0, s4_kg_ff};
      s5_pb_in = {7'd0, s4_pix_ff.blue}  * {8'd0, s4_kb_ff};
   end

   always_ff @(posedge clock) begin
      if (adv5) begin
         s5_pr_ff <= s5_pr_in;
         s5_pg_ff <= s5_pg_in;
         s5_pb_ff <= s5_pb_in;
      end
   end

   // stage 6: divide by 100 through the reciprocal multiply
   always_comb begin
      q_r = {13'd0, s5_pr_ff} * DIV100_MUL;
      q_g = {13'd0, s5_pg_ff} * DIV100_MUL;
      q_b = {13'd0, s5_pb_ff} * DIV100_MUL;
      s6_pix_in.red   = q_r[DIV100_SHIFT +: 8];
      s6_pix_in.green = q_g[DIV100_SHIFT +: 8];
      s6_pix_in.blue  = q_b[DIV100_SHIFT +: 8];
   end

   always_ff @(posedge clock) begin
      if (adv6) begin
         s6_pix_ff <= s6_pix_in;
      end
   end

   // input can only stall when every stage holds an item
   a_full_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && v6_ff))
      else $error("input stalled with a free pipeline stage");

   // profile off never takes the base blend
   a_off_no_base: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && s1_prof_ff == PROF_OFF) |-> !s1_base_ff)
      else $error("base blend enabled with profile off");

   // green mix excludes a luma blend and a red scale
   a_mix_alone: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && s3_adj_ff.mix) |-> (s3_adj_ff.weight == 8'd0
                                    && s3_adj_ff.k_red == PCT_UNITY))
      else $error("green mix combined with blend or red scale");

   // nothing is presented in the cycle after reset
   a_empty_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

>>> rtl/core/pcr_stats.sv
`default_nettype none

module pcr_stats
   import pcr_pkg::*;
(
   input  pix_type    pix,
   input  logic [2:0] profile,
   output logic [7:0] luma,
   output logic       base_en,
   output logic       low
);

   logic [7:0] mx;
   logic [7:0] mn;
   logic [7:0] chroma;

   always_comb begin
      mx = (pix.red > pix.green) ? ((pix.red > pix.blue) ? pix.red : pix.blue)
                                 : ((pix.green > pix.blue) ? pix.green : pix.blue);
      mn = (pix.red < pix.green) ? ((pix.red < pix.blue) ? pix.red : pix.blue)
                                 : ((pix.green < pix.blue) ? pix.green : pix.blue);
      chroma = mx - mn;
      luma   = luma_of(pix);
      low    = (mx < LOW_MAX_LIMIT);
      base_en = (profile != PROF_OFF) && (mx < BASE_MAX_LIMIT)
             && (luma > BASE_LUMA_MIN) && (chroma > BASE_CHROMA_MIN);
   end

endmodule

`default_nettype wire

>>> rtl/core/pcr_blend.sv
`default_nettype none

module pcr_blend
   import pcr_pkg::*;
(
   input  pix_type    pix,
   input  logic [7:0] luma,
   input  logic [7:0] weight,
   output pix_type    blended
);

   logic [15:0] inv_w;
   logic [15:0] luma_part;
   logic [15:0] sum_r;
   logic [15:0] sum_g;
   logic [15:0] sum_b;

   // c*(256-w) + L*w never exceeds 255*256, so 16 bits hold it
   always_comb begin
      inv_w     = 16'd256 - {8'd0, weight};
      luma_part = {8'd0, luma} * {8'd0, weight};
      sum_r     = {8'd0, pix.red}   * inv_w + luma_part;
      sum_g     = {8'd0, pix.green} * inv_w + luma_part;
      sum_b     = {8'd0, pix.blue}  * inv_w + luma_part;
      blended.red   = sum_r[15:8];
      blended.green = sum_g[15:8];
      blended.blue  = sum_b[15:8];
   end

endmodule

`default_nettype wire

>>> rtl/core/pcr_select.sv
`default_nettype none

module pcr_select
   import pcr_pkg::*;
(
   input  pix_type    pix,
   input  logic       low,
   input  logic [2:0] profile,
   output adj_type    adj
);

   logic [8:0] r;
   logic [8:0] g;
   logic [8:0] b;

   always_comb begin
      r = {1'b0, pix.red};
      g = {1'b0, pix.green};
      b = {1'b0, pix.blue};

      adj.weight  = 8'd0;
      adj.mix     = 1'b0;
      adj.k_red   = PCT_UNITY;
      adj.k_green = PCT_UNITY;
      adj.k_blue  = PCT_UNITY;

      if (low) begin
         unique case (profile)
            PROF_PURPLE: begin
               if (r > g + 9'd12 && b > g + 9'd16 && r > 9'd48 && b > 9'd48) begin
                  adj.weight  = 8'd78;
                  adj.k_red   = 7'd92;
                  adj.k_green = 7'd92;
                  adj.k_blue  = 7'd94;
               end
            end
            PROF_CYAN: begin
               if (b > r + 9'd18 && g > r + 9'd8) begin
                  adj.weight  = 8'd64;
                  adj.k_red   = 7'd92;
                  adj.k_green = 7'd92;
                  adj.k_blue  = 7'd88;
               end
            end
            PROF_RED_CYAN: begin
               priority if (r > g + 9'd28 && r > b + 9'd24) begin
                  adj.weight = 8'd52;
                  adj.k_red  = 7'd90;
               end else if (b > r + 9'd16 && g > r + 9'd10) begin
                  adj.weight = 8'd48;
                  adj.k_blue = 7'd92;
               end else begin
                  // no match: hold the defaults
               end
            end
            PROF_BLUE_GREEN: begin
               priority if (b > r + 9'd18 && g > r + 9'd6) begin
                  adj.weight = 8'd48;
                  adj.k_blue = 7'd92;
               end else if (g > r + 9'd18 && g > b + 9'd8) begin
                  adj.mix     = 1'b1;
                  adj.k_green = 7'd91;
                  adj.k_blue  = 7'd94;
               end else begin
                  // no match: hold the defaults
               end
            end
            PROF_BLUE_RED: begin
               priority if (b > r + 9'd20 && b > g + 9'd8) begin
                  adj.weight = 8'd44;
                  adj.k_blue = 7'd90;
               end else if (r > g + 9'd26 && r > b + 9'd22) begin
                  adj.weight = 8'd40;
                  adj.k_red  = 7'd91;
               end else begin
                  // no match: hold the defaults
               end
            end
            default: begin
               // off and the unused codes 6 and 7: no further change
            end
         endcase
      end
   end

endmodule

`default_nettype wire
